### design/assert_macros.svh
// assertion macros used by the top level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/sidta_pkg.sv
// types, constants and digit weight table for the integer to decimal text block
package sidta_pkg;

  localparam int ValueW    = 32;
  localparam int CharW     = 8;
  localparam int NumDigits = 10;
  localparam int IdxW      = 4;
  // wide enough to hold 9 * 10^9 and a signed difference against a 32-bit magnitude
  localparam int MulW      = 35;

  localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CH_NINE  = 8'h39;
  localparam logic [CharW-1:0] CH_MINUS = 8'h2D;

  typedef logic [NumDigits-1:0][NumDigits-1:0][MulW-1:0] mult_tbl_t;

  typedef struct packed {
    logic              neg;
    logic [ValueW-1:0] mag;
    logic [IdxW-1:0]   idx;
  } item_t;

  // entry [i][k] is k * 10^i
  function automatic mult_tbl_t build_mult_tbl();
    mult_tbl_t       tbl;
    logic [MulW-1:0] p;
    int              i;
    int              k;
    p = MulW'(1);
    for (i = 0; i < NumDigits; i++) begin
      for (k = 0; k < NumDigits; k++) begin
        tbl[i][k] = p * MulW'(k);
      end
      p = p * MulW'(10);
    end
    return tbl;
  endfunction

  localparam mult_tbl_t MULT_TBL = build_mult_tbl();

endpackage

### design/sidta_prep.sv
// input register, magnitude and leading digit position
module sidta_prep (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [sidta_pkg::ValueW-1:0] value,
  output logic                              item_valid,
  input  logic                              item_ready,
  output sidta_pkg::item_t                  item
);

  logic                         valid_q;
  logic [sidta_pkg::ValueW-1:0] value_q;
  logic [sidta_pkg::ValueW-1:0] mag;
  logic [sidta_pkg::NumDigits-2:0] above;

  assign in_ready   = !valid_q || item_ready;
  assign item_valid = valid_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_ready) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      value_q <= value;
    end
  end

  // magnitude as unsigned, so the most negative value comes out right
  assign mag = value_q[sidta_pkg::ValueW-1] ? (~value_q + 1'b1) : value_q;

  // digit count minus one is the number of powers of ten from 10 up that are at or below mag
  always_comb begin
    for (int k = 1; k < sidta_pkg::NumDigits; k++) begin
      above[k-1] = ({(sidta_pkg::MulW - sidta_pkg::ValueW)'(0), mag} >=
                    sidta_pkg::MULT_TBL[k][1]);
    end
  end

  assign item = '{neg: value_q[sidta_pkg::ValueW-1],
                  mag: mag,
                  idx: sidta_pkg::IdxW'($countones(above))};

endmodule

### design/sidta_digit.sv
// digit extraction, one character per cycle unless the output stalls, and the result register
module sidta_digit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  sidta_pkg::item_t             item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sidta_pkg::CharW-1:0]  character,
  output logic                         last
);

  logic                           busy;
  logic                           sign_pend;
  logic [sidta_pkg::ValueW-1:0]   mag;
  logic [sidta_pkg::IdxW-1:0]     idx;
  logic [sidta_pkg::CharW-1:0]    char_q;
  logic                           last_q;

  logic                           out_free;
  logic                           step;
  logic                           finishing;
  logic [sidta_pkg::MulW-1:0]     rem [sidta_pkg::NumDigits];
  logic [sidta_pkg::NumDigits-2:0] ge;
  logic [sidta_pkg::IdxW-1:0]     digit;
  logic [sidta_pkg::ValueW-1:0]   mag_next;
  logic [sidta_pkg::CharW-1:0]    char_next;
  logic                           last_next;

  assign out_free   = !out_valid || out_ready;
  assign step       = busy && out_free;
  assign finishing  = step && !sign_pend && (idx == '0);
  assign item_ready = !busy || finishing;

  // all nine trial subtractions side by side, the borrow gives the compare
  always_comb begin
    rem[0] = {(sidta_pkg::MulW - sidta_pkg::ValueW)'(0), mag};
    for (int k = 1; k < sidta_pkg::NumDigits; k++) begin
      rem[k]  = {(sidta_pkg::MulW - sidta_pkg::ValueW)'(0), mag} -
                sidta_pkg::MULT_TBL[idx][k];
      ge[k-1] = !rem[k][sidta_pkg::MulW-1];
    end
  end

  assign digit    = sidta_pkg::IdxW'($countones(ge));
  assign mag_next = rem[digit][sidta_pkg::ValueW-1:0];

  always_comb begin
    if (sign_pend) begin
      char_next = sidta_pkg::CH_MINUS;
      last_next = 1'b0;
    end else begin
      char_next = sidta_pkg::CH_ZERO + {(sidta_pkg::CharW - sidta_pkg::IdxW)'(0), digit};
      last_next = (idx == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      sign_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= step;
      end
      if (step) begin
        if (sign_pend) begin
          sign_pend <= 1'b0;
        end else if (idx == '0) begin
          busy <= 1'b0;
        end
      end
      if (item_valid && item_ready) begin
        busy      <= 1'b1;
        sign_pend <= item.neg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      char_q <= char_next;
      last_q <= last_next;
      if (!sign_pend) begin
        mag <= mag_next;
        idx <= idx - 1'b1;
      end
    end
    if (item_valid && item_ready) begin
      mag <= item.mag;
      idx <= item.idx;
    end
  end

  assign character = char_q;
  assign last      = last_q;

endmodule

### design/signed_int_to_decimal_ascii.sv
// top level: signed 32-bit integer to decimal ascii text
//
//   channel   dir   handshake              payload
//   input     in    in_valid / in_ready    value (32 bit signed)
//   result    out   out_valid / out_ready  character (8 bit), last
//
// one character leaves per cycle while out_ready is high; an item has
// 1 to 11 characters (sign plus up to ten digits)
// the digit unit does one trial-subtract step per cycle unless the result stalls;
// the next item is loaded at the edge that registers its predecessor's last digit
// an input register and the result register decouple both sides
// rst is synchronous and clears all valid and busy flags; no state spans items
`include "assert_macros.svh"

module signed_int_to_decimal_ascii (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [sidta_pkg::ValueW-1:0]   value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [sidta_pkg::CharW-1:0]           character,
  output logic                                  last
);

  logic             item_valid;
  logic             item_ready;
  sidta_pkg::item_t item;
  logic             xfer;
  logic             is_minus;
  logic             is_digit;
  logic             is_zero;

  sidta_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  sidta_digit u_digit (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .character  (character),
    .last       (last)
  );

  assign xfer     = out_valid && out_ready;
  assign is_minus = (character == sidta_pkg::CH_MINUS);
  assign is_digit = (character >= sidta_pkg::CH_ZERO) && (character <= sidta_pkg::CH_NINE);
  assign is_zero  = (character == sidta_pkg::CH_ZERO);

  `ASSERT_ANY(a_rst_quiet, rst |=> !out_valid, "result valid right after reset")
  `ASSERT_CLK(a_minus_not_last, out_valid |-> !(is_minus && last), "minus sign marked last")
  `ASSERT_CLK(a_char_range, out_valid |-> (is_minus || is_digit), "character out of range")
  `ASSERT_CLK(a_no_minus_zero, (xfer && is_minus) |=> !(out_valid && is_zero), "zero after minus")

endmodule
